FILE: rtl/spm_pkg.sv
// Shared types and constants for the star pattern NFA matcher.
// Holds the request and result structs, the cell link struct and the
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package spm_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STAR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd3;

    // Widths of the fixed registers
    localparam int COUNT_W   = 5;
    localparam int STAR_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int LANES_LOW = 8;

    // One text request
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              string_start;
    } in_t;

    // One match result
    typedef struct packed {
        logic full_match;
        logic still_alive;
    } out_t;

    // Signals one cell hands to the cell above it
    typedef struct packed {
        logic hold;       // closure of the current set passes through a star
        logic step;       // a literal match moves activity up one position
        logic next_hold;  // closure of the new set passes through a star
    } link_t;

    // Per-position results a cell reports to the top level
    typedef struct packed {
        logic nxt;     // new active bit of this position
        logic closed;  // this position in the closure of the new set
    } tap_t;

endpackage

FILE: rtl/spm_cell.sv
// One pattern position of the matcher chain: holds its active bit and
// ripples closure and match activity to the next position.
// Depends on spm_pkg.
`timescale 1ns / 1ps

module spm_cell #(
    parameter bit HOME = 1'b0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       restart,
    input  logic                       en,
    input  logic                       keep,
    input  logic                       star,
    input  logic [spm_pkg::BYTE_W-1:0] literal,
    input  logic [spm_pkg::BYTE_W-1:0] text_byte,
    input  logic                       byte_live,
    input  spm_pkg::link_t             link_in,
    output spm_pkg::link_t             link_out,
    output spm_pkg::tap_t              tap
);
    import spm_pkg::*;

    logic active_reg;
    logic active_next;
    logic act;
    logic cur;
    logic hit;
    logic nxt;
    logic closed;

    // Current position, closed over starred elements below
    always_comb
    begin
        act = restart ? HOME : (active_reg & keep);
        cur = act | link_in.hold;
    end

    // Literal match and the new active bit
    always_comb
    begin
        hit    = cur & en & byte_live & (literal == text_byte);
        nxt    = (hit & star) | link_in.step;
        closed = nxt | link_in.next_hold;
    end

    // Hand-off to the next position
    always_comb
    begin
        link_out.hold      = cur & star & en;
        link_out.step      = hit & ~star;
        link_out.next_hold = closed & star & en;
        tap.nxt            = nxt;
        tap.closed         = closed;
    end

    // Active bit update on each accepted request
    assign active_next = accept ? nxt : active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= HOME;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

endmodule

FILE: rtl/star_pattern_nfa_matcher.sv
// Star pattern NFA matcher: top level with configuration registers,
// the chain of position cells and the result register.
// Depends on spm_pkg and spm_cell.
//
// Usage:
//   The text channel (text_valid, text_stall, text_data) carries one byte a
//   request; string_start restarts matching at position zero before it.
//   The result channel (result_valid, result_stall, result_data) returns one
//   result for every byte: full_match when the text so far matches the whole
//   pattern, still_alive when any position stays active.
//   A request is taken at a clock edge with valid high and stall low.
//   The result is registered at the edge that takes the byte. Throughput
//   is one byte per cycle while the receiver does not stall; the figure
//   is set by the ripple of closure and match activity through the cell
//   chain, which is purely combinational.
//   A new byte is taken while the result register is free or being drained;
//   while the receiver stalls a waiting result, text_stall is high and the
//   result holds.
//   Write configuration through cfg_we, cfg_index and cfg_data while no
//   request is in flight (not enforced). Reset clears all configuration
//   registers, empties the result register; only position zero is active.
`timescale 1ns / 1ps

module star_pattern_nfa_matcher #(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           text_valid,
    output logic                           text_stall,
    input  spm_pkg::in_t                   text_data,
    output logic                           result_valid,
    input  logic                           result_stall,
    output spm_pkg::out_t                  result_data,
    input  logic                           cfg_we,
    input  logic [spm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import spm_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    // Configuration registers
    logic [CFG_DATA_W-1:0]   pat_lo_reg;
    logic [CFG_DATA_W-1:0]   pat_hi_reg;
    logic [MAX_ELEMENTS-1:0] star_reg;
    logic [COUNT_W-1:0]      count_reg;

    // Handshake and result register
    logic accept;
    logic result_valid_reg;
    logic result_valid_next;
    out_t result_reg;
    out_t result_next;

    // Chain signals
    logic [CNT_W-1:0]        n_used;
    logic [MAX_ELEMENTS-1:0] en_vec;
    logic [MAX_ELEMENTS-1:0] keep_vec;
    logic [MAX_ELEMENTS-1:0] last_vec;
    link_t                   link [0:MAX_ELEMENTS];
    tap_t                    taps [0:MAX_ELEMENTS-1];
    logic [MAX_ELEMENTS:0]   nxt_vec;
    logic [MAX_ELEMENTS:0]   fin_vec;
    logic                    byte_live;
    logic                    top_nxt;
    logic                    top_closed;
    logic                    top_is_last;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            star_reg   <= '0;
            count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAT_LO: pat_lo_reg <= cfg_data;
                CFG_PAT_HI: pat_hi_reg <= cfg_data;
                CFG_STAR:   star_reg   <= cfg_data[MAX_ELEMENTS-1:0];
                CFG_COUNT:  count_reg  <= cfg_data[COUNT_W-1:0];
                default:    star_reg   <= star_reg;
            endcase
        end
    end

    // Element count, capped at the chain length
    always_comb
    begin
        if (count_reg > COUNT_W'(MAX_ELEMENTS))
        begin
            n_used = CNT_W'(MAX_ELEMENTS);
        end
        else
        begin
            n_used = count_reg[CNT_W-1:0];
        end
    end

    assign byte_live = (text_data.text_byte != '0);
    assign link[0]   = '0;

    // Row of position cells
    for (genvar j = 0; j < MAX_ELEMENTS; j++)
    begin : g_cell
        logic [BYTE_W-1:0] lit;

        assign en_vec[j]   = (n_used > CNT_W'(j));
        assign keep_vec[j] = (n_used >= CNT_W'(j));
        assign last_vec[j] = (n_used == CNT_W'(j));

        if (j < LANES_LOW)
        begin : g_lo
            assign lit = pat_lo_reg[BYTE_W*j +: BYTE_W];
        end
        else
        begin : g_hi
            assign lit = pat_hi_reg[BYTE_W*(j-LANES_LOW) +: BYTE_W];
        end

        spm_cell #(
            .HOME ((j == 0) ? 1'b1 : 1'b0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .accept    (accept),
            .restart   (text_data.string_start),
            .en        (en_vec[j]),
            .keep      (keep_vec[j]),
            .star      (star_reg[j]),
            .literal   (lit),
            .text_byte (text_data.text_byte),
            .byte_live (byte_live),
            .link_in   (link[j]),
            .link_out  (link[j+1]),
            .tap       (taps[j])
        );

        assign nxt_vec[j] = taps[j].nxt;
        assign fin_vec[j] = taps[j].closed & last_vec[j];
    end

    // Topmost position: reachable only from below, never passes activity on,
    // so its stored bit would never be read and is not kept.
    assign top_nxt     = link[MAX_ELEMENTS].step;
    assign top_closed  = top_nxt | link[MAX_ELEMENTS].next_hold;
    assign top_is_last = (n_used == CNT_W'(MAX_ELEMENTS));
    assign nxt_vec[MAX_ELEMENTS] = top_nxt;
    assign fin_vec[MAX_ELEMENTS] = top_closed & top_is_last;

    // Handshake: take a request while the result register can be refilled
    assign text_stall = result_valid_reg & result_stall;
    assign accept     = text_valid & ~text_stall;

    always_comb
    begin
        result_valid_next       = accept | (result_valid_reg & result_stall);
        result_next.full_match  = |fin_vec;
        result_next.still_alive = |nxt_vec;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

`ifndef SYNTHESIS
    // The text side only waits on a result that is still held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> result_valid_reg)
        else $error("text_stall raised with no pending result");

    // Every accepted request leaves a result in the register
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg)
        else $error("accepted request produced no result");

    // A full match needs at least one surviving position
    a_match_alive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!result_reg.full_match || result_reg.still_alive))
        else $error("full_match reported with an empty active set");

    // The epsilon byte kills every position
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !byte_live) |=> (!result_reg.still_alive && !result_reg.full_match))
        else $error("zero byte left active positions");
`endif

endmodule
